// ===== src/bcfg_pkg.sv =====
`timescale 1ns / 1ps

package bcfg_pkg;

	// field widths
	localparam int MV_W       = 15;
	localparam int MAG_W      = 16;
	localparam int CAP_W      = 16;
	localparam int TPH_W      = 24;
	localparam int THR_W      = 16;
	localparam int SET_W      = 8;
	localparam int ACC_W      = 42;
	localparam int CHG_W      = 18;
	localparam int SOC_W      = 7;
	localparam int BAR_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// divider shape
	localparam int NUM_W = 48;
	localparam int DEN_W = TPH_W + CAP_W;
	localparam int QUO_W = 17;

	// voltage / capacity table
	localparam int TABLE_ENTRIES = 51;
	localparam int TABLE_SLOTS   = 64;
	localparam int SLOT_W        = $clog2(TABLE_SLOTS);
	localparam int TBL_N         = (TABLE_ENTRIES > TABLE_SLOTS) ? TABLE_SLOTS : TABLE_ENTRIES;
	localparam int TBL_ADDR_W    = $clog2(TBL_N);
	localparam int TBL_IDX_W     = $clog2(TBL_N + 1);
	localparam int ENTRY_W       = 2 * CAP_W;

	localparam logic [ENTRY_W-1:0] VC_TABLE [TABLE_SLOTS] = '{
		{16'd10269, 16'd80},    {16'd10699, 16'd330},   {16'd10883, 16'd580},
		{16'd10957, 16'd830},   {16'd10994, 16'd1080},  {16'd11028, 16'd1330},
		{16'd11072, 16'd1580},  {16'd11127, 16'd1830},  {16'd11188, 16'd2080},
		{16'd11249, 16'd2330},  {16'd11307, 16'd2580},  {16'd11360, 16'd2830},
		{16'd11406, 16'd3080},  {16'd11448, 16'd3330},  {16'd11488, 16'd3580},
		{16'd11527, 16'd3830},  {16'd11567, 16'd4080},  {16'd11610, 16'd4330},
		{16'd11657, 16'd4580},  {16'd11707, 16'd4830},  {16'd11760, 16'd5080},
		{16'd11816, 16'd5330},  {16'd11872, 16'd5580},  {16'd11928, 16'd5830},
		{16'd11983, 16'd6080},  {16'd12036, 16'd6330},  {16'd12087, 16'd6580},
		{16'd12136, 16'd6830},  {16'd12183, 16'd7080},  {16'd12229, 16'd7330},
		{16'd12275, 16'd7580},  {16'd12319, 16'd7830},  {16'd12363, 16'd8080},
		{16'd12406, 16'd8330},  {16'd12447, 16'd8580},  {16'd12486, 16'd8830},
		{16'd12521, 16'd9080},  {16'd12551, 16'd9330},  {16'd12575, 16'd9580},
		{16'd12594, 16'd9830},  {16'd12606, 16'd10080}, {16'd12613, 16'd10330},
		{16'd12616, 16'd10580}, {16'd12617, 16'd10830}, {16'd12617, 16'd11080},
		{16'd12619, 16'd11330}, {16'd12623, 16'd11580}, {16'd12628, 16'd11830},
		{16'd12634, 16'd12080}, {16'd12637, 16'd12330}, {16'd12637, 16'd12500},
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
		32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
	};

	// nearest-voltage capacity, elaboration use only
	function automatic logic [CAP_W-1:0] nearest_cap(input logic [MV_W-1:0] mv);
		logic [CAP_W-1:0] best;
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] v;
		logic [CAP_W-1:0] d;
		best = '1;
		cap  = '0;
		for (int i = 0; i < TBL_N; i++) begin
			v = VC_TABLE[i][ENTRY_W-1:CAP_W];
			d = ({1'b0, mv} >= v) ? ({1'b0, mv} - v) : (v - {1'b0, mv});
			if (d < best) begin
				best = d;
				cap  = VC_TABLE[i][CAP_W-1:0];
			end
		end
		return cap;
	endfunction

	// reset values
	localparam logic [CAP_W-1:0] CAP_RST  = 16'd12500;
	localparam logic [TPH_W-1:0] TPH_RST  = 24'd360000;
	localparam logic [THR_W-1:0] THR_RST  = 16'd200;
	localparam logic [SET_W-1:0] SET_RST  = 8'd20;
	localparam logic [CAP_W-1:0] TCAP_RST = nearest_cap('0);

	// saturation limits
	localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [CHG_W-1:0] CHG_MAX = {1'b0, {(CHG_W-1){1'b1}}};
	localparam logic [CHG_W-1:0] CHG_MIN = {1'b1, {(CHG_W-1){1'b0}}};
	localparam logic [SOC_W-1:0] SOC_FULL = 7'd100;

	// bar thresholds
	localparam logic [SOC_W-1:0] BAR1_SOC = 7'd10;
	localparam logic [SOC_W-1:0] BAR2_SOC = 7'd20;
	localparam logic [SOC_W-1:0] BAR3_SOC = 7'd40;
	localparam logic [SOC_W-1:0] BAR4_SOC = 7'd60;
	localparam logic [SOC_W-1:0] BAR5_SOC = 7'd80;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY  = 2'd0,
		CFG_TPH       = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_SETTLE    = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_TICK   = 1'b1
	} kind_t;

	typedef struct packed {
		logic            start;
		logic [MV_W-1:0] mv;
	} srch_req_t;

	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CAP_W-1:0] cap;
	} srch_sts_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_sts_t;

endpackage

// ===== src/bcfg_if.sv =====
`timescale 1ns / 1ps

interface bcfg_sample_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [15:0]                    bus_raw;
	logic [15:0]                    shunt_raw;

	modport source (output valid, kind, bus_raw, shunt_raw, input ready);
	modport sink (input valid, kind, bus_raw, shunt_raw, output ready);
	modport monitor (input valid, ready, kind, bus_raw, shunt_raw);
endinterface

interface bcfg_result_if;
	logic                                  valid;
	logic                                  ready;
	logic [bcfg_pkg::MV_W-1:0]             bus_millivolts;
	logic [bcfg_pkg::MAG_W-1:0]            current_magnitude;
	logic                                  current_negative;
	logic [bcfg_pkg::CAP_W-1:0]            table_capacity;
	logic                                  gauge_started;
	logic signed [bcfg_pkg::CHG_W-1:0]     charge_whole;
	logic [bcfg_pkg::SOC_W-1:0]            soc_percent;
	logic [bcfg_pkg::BAR_W-1:0]            led_bars;

	modport source (output valid, bus_millivolts, current_magnitude, current_negative,
		table_capacity, gauge_started, charge_whole, soc_percent, led_bars, input ready);
	modport sink (input valid, bus_millivolts, current_magnitude, current_negative,
		table_capacity, gauge_started, charge_whole, soc_percent, led_bars, output ready);
	modport monitor (input valid, ready, bus_millivolts, current_magnitude, current_negative,
		table_capacity, gauge_started, charge_whole, soc_percent, led_bars);
endinterface

interface bcfg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bcfg_pkg::CFG_IDX_W-1:0]    index;
	logic [bcfg_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

// ===== src/battery_coulomb_fuel_gauge.sv =====
`timescale 1ns / 1ps

// channel   dir   handshake      payload
// sample    in    valid/ready    kind, bus_raw, shunt_raw
// result    out   valid/ready    bus_millivolts .. led_bars
// cfg       in    valid/ready    index, data (always ready)
//
// One request at a time. A sample steps through the 51 table entries over the one
// read port of the table memory; a tick uses the 17-step divider, which serves
// both SOC and charge, once before seeding and twice after (once when the
// charge is not positive). After reset the table memory is filled with
// sample.ready low; cfg writes are taken throughout. The result register lets
// the next sample be taken while a result waits on result.ready.
module battery_coulomb_fuel_gauge (
	input  logic                 clk,
	input  logic                 arst_n,
	bcfg_sample_if.sink          sample,
	bcfg_result_if.source        result,
	bcfg_cfg_if.sink             cfg
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_SRCH_GO   = 11'b000_0000_0010,
		ST_SRCH_WAIT = 11'b000_0000_0100,
		ST_SEED      = 11'b000_0000_1000,
		ST_ACC       = 11'b000_0001_0000,
		ST_SOC_MUL   = 11'b000_0010_0000,
		ST_SOC_GO    = 11'b000_0100_0000,
		ST_SOC_WAIT  = 11'b000_1000_0000,
		ST_CHG_GO    = 11'b001_0000_0000,
		ST_CHG_WAIT  = 11'b010_0000_0000,
		ST_OUT       = 11'b100_0000_0000
	} state_t;

	localparam int ACC_W = bcfg_pkg::ACC_W;
	localparam int NUM_W = bcfg_pkg::NUM_W;
	localparam int DEN_W = bcfg_pkg::DEN_W;

	state_t                          state_q;

	logic [bcfg_pkg::CAP_W-1:0]      cap_q;
	logic [bcfg_pkg::TPH_W-1:0]      tph_q;
	logic [bcfg_pkg::THR_W-1:0]      thr_q;
	logic [bcfg_pkg::SET_W-1:0]      settle_q;

	logic [bcfg_pkg::MV_W-1:0]       mv_q;
	logic [bcfg_pkg::MAG_W-1:0]      mag_q;
	logic                            neg_q;
	logic [bcfg_pkg::SET_W-1:0]      cnt_q;
	logic                            seeded_q;
	logic [ACC_W-1:0]                acc_q;
	logic [bcfg_pkg::SOC_W-1:0]      soc_q;
	logic [bcfg_pkg::CAP_W-1:0]      tcap_q;
	logic [bcfg_pkg::CHG_W-1:0]      whole_q;
	logic [NUM_W-1:0]                num_q;
	logic [DEN_W-1:0]                den_q;

	logic                            o_vld_q;
	logic [bcfg_pkg::MV_W-1:0]       o_mv_q;
	logic [bcfg_pkg::MAG_W-1:0]      o_mag_q;
	logic                            o_neg_q;
	logic [bcfg_pkg::CAP_W-1:0]      o_tcap_q;
	logic                            o_started_q;
	logic [bcfg_pkg::CHG_W-1:0]      o_charge_q;
	logic [bcfg_pkg::SOC_W-1:0]      o_soc_q;
	logic [bcfg_pkg::BAR_W-1:0]      o_bars_q;

	bcfg_pkg::srch_req_t             srch_req;
	bcfg_pkg::srch_sts_t             srch_sts;
	bcfg_pkg::div_req_t              div_req;
	bcfg_pkg::div_sts_t              div_sts;

	logic                            accept;
	logic                            can_load;
	logic [bcfg_pkg::TPH_W-1:0]      eff_tph;
	logic [bcfg_pkg::CAP_W-1:0]      eff_cap;
	logic [bcfg_pkg::CAP_W-1:0]      mul_b;
	logic [DEN_W-1:0]                prod;
	logic                            seed_go;
	logic [bcfg_pkg::MAG_W-1:0]      in_mag;
	logic [ACC_W:0]                  acc_ext;
	logic [ACC_W:0]                  mag_ext;
	logic [ACC_W:0]                  acc_sum;
	logic [ACC_W-1:0]                acc_sat;
	logic [ACC_W-1:0]                acc_abs;
	logic [ACC_W-2:0]                acc_pos;
	logic [NUM_W-1:0]                pos_ext;
	logic [NUM_W-1:0]                times100;
	logic                            acc_nonpos;
	logic [bcfg_pkg::CHG_W-1:0]      quo_ext;
	logic [bcfg_pkg::CHG_W-1:0]      whole_d;
	logic [bcfg_pkg::SOC_W-1:0]      soc_d;
	logic [bcfg_pkg::BAR_W-1:0]      bars_d;

	assign accept   = sample.valid && sample.ready;
	assign can_load = !o_vld_q || result.ready;
	assign sample.ready = (state_q == ST_IDLE) && srch_sts.idle;
	assign cfg.ready    = 1'b1;

	assign eff_tph = (tph_q == '0) ? bcfg_pkg::TPH_W'(1) : tph_q;
	assign eff_cap = (cap_q == '0) ? bcfg_pkg::CAP_W'(1) : cap_q;

	// one multiplier: seed charge or SOC divisor
	assign seed_go = !seeded_q && (cnt_q > settle_q) && !neg_q && (mag_q != thr_q);
	assign mul_b   = ((state_q == ST_SEED) && (mag_q > thr_q)) ? srch_sts.cap : eff_cap;
	assign prod    = DEN_W'(eff_tph) * DEN_W'(mul_b);

	// the negated minimum wraps to 0x8000, which is its magnitude
	assign in_mag = sample.shunt_raw[15] ? (16'd0 - sample.shunt_raw) : sample.shunt_raw;

	assign acc_ext = {acc_q[ACC_W-1], acc_q};
	assign mag_ext = (ACC_W + 1)'(mag_q);
	assign acc_sum = neg_q ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
	assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
		? (acc_sum[ACC_W] ? bcfg_pkg::ACC_MIN : bcfg_pkg::ACC_MAX)
		: acc_sum[ACC_W-1:0];

	assign acc_abs    = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
	assign acc_nonpos = acc_q[ACC_W-1] || (acc_q == '0);
	assign acc_pos    = acc_q[ACC_W-2:0];
	assign pos_ext    = NUM_W'(acc_pos);
	assign times100   = (pos_ext << 6) + (pos_ext << 5) + (pos_ext << 2);

	assign srch_req.start = (state_q == ST_SRCH_GO);
	assign srch_req.mv    = mv_q;

	assign div_req.start = (state_q == ST_SOC_GO) || (state_q == ST_CHG_GO);
	assign div_req.num   = (state_q == ST_SOC_GO) ? num_q : NUM_W'(acc_abs);
	assign div_req.den   = (state_q == ST_SOC_GO) ? den_q : DEN_W'(eff_tph);

	assign quo_ext = bcfg_pkg::CHG_W'(div_sts.quo);
	assign whole_d = acc_q[ACC_W-1]
		? (div_sts.ovf ? bcfg_pkg::CHG_MIN : (bcfg_pkg::CHG_W'(0) - quo_ext))
		: (div_sts.ovf ? bcfg_pkg::CHG_MAX : quo_ext);
	assign soc_d = (div_sts.ovf || (div_sts.quo > bcfg_pkg::QUO_W'(bcfg_pkg::SOC_FULL)))
		? bcfg_pkg::SOC_FULL : div_sts.quo[bcfg_pkg::SOC_W-1:0];

	always_comb begin
		priority if (soc_q <= bcfg_pkg::BAR1_SOC) bars_d = 3'd0;
		else if (soc_q <= bcfg_pkg::BAR2_SOC) bars_d = 3'd1;
		else if (soc_q <= bcfg_pkg::BAR3_SOC) bars_d = 3'd2;
		else if (soc_q <= bcfg_pkg::BAR4_SOC) bars_d = 3'd3;
		else if (soc_q <= bcfg_pkg::BAR5_SOC) bars_d = 3'd4;
		else bars_d = 3'd5;
	end

	bcfg_search u_search (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (srch_req),
		.sts    (srch_sts)
	);

	bcfg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= bcfg_pkg::CAP_RST;
			tph_q    <= bcfg_pkg::TPH_RST;
			thr_q    <= bcfg_pkg::THR_RST;
			settle_q <= bcfg_pkg::SET_RST;
		end else if (cfg.valid) begin
			unique case (bcfg_pkg::cfg_idx_t'(cfg.index))
				bcfg_pkg::CFG_CAPACITY:  cap_q    <= cfg.data[bcfg_pkg::CAP_W-1:0];
				bcfg_pkg::CFG_TPH:       tph_q    <= cfg.data[bcfg_pkg::TPH_W-1:0];
				bcfg_pkg::CFG_THRESHOLD: thr_q    <= cfg.data[bcfg_pkg::THR_W-1:0];
				bcfg_pkg::CFG_SETTLE:    settle_q <= cfg.data[bcfg_pkg::SET_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mv_q     <= '0;
			mag_q    <= '0;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			seeded_q <= 1'b0;
			acc_q    <= '0;
			soc_q    <= '0;
			tcap_q   <= bcfg_pkg::TCAP_RST;
			whole_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (bcfg_pkg::kind_t'(sample.kind) == bcfg_pkg::KIND_SAMPLE) begin
							mv_q  <= {sample.bus_raw[15:3], 2'b00};
							neg_q <= sample.shunt_raw[15];
							mag_q <= in_mag;
							if (cnt_q != '1) begin
								cnt_q <= cnt_q + bcfg_pkg::SET_W'(1);
							end
							state_q <= ST_SRCH_GO;
						end else if (seeded_q) begin
							state_q <= ST_ACC;
						end else begin
							state_q <= ST_CHG_GO;
						end
					end
				end
				ST_SRCH_GO: state_q <= ST_SRCH_WAIT;
				ST_SRCH_WAIT: begin
					if (srch_sts.done) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					tcap_q <= srch_sts.cap;
					if (seed_go) begin
						acc_q    <= ACC_W'(prod);
						seeded_q <= 1'b1;
					end
					state_q <= ST_CHG_GO;
				end
				ST_ACC: begin
					acc_q   <= acc_sat;
					state_q <= ST_SOC_MUL;
				end
				ST_SOC_MUL: begin
					if (acc_nonpos) begin
						soc_q   <= '0;
						state_q <= ST_CHG_GO;
					end else begin
						state_q <= ST_SOC_GO;
					end
				end
				ST_SOC_GO: state_q <= ST_SOC_WAIT;
				ST_SOC_WAIT: begin
					if (div_sts.done) begin
						soc_q   <= soc_d;
						state_q <= ST_CHG_GO;
					end
				end
				ST_CHG_GO: state_q <= ST_CHG_WAIT;
				ST_CHG_WAIT: begin
					if (div_sts.done) begin
						whole_q <= whole_d;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// SOC operands, held for the divider start
	always_ff @(posedge clk) begin
		if (state_q == ST_SOC_MUL) begin
			num_q <= times100;
			den_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q     <= 1'b0;
			o_mv_q      <= '0;
			o_mag_q     <= '0;
			o_neg_q     <= 1'b0;
			o_tcap_q    <= '0;
			o_started_q <= 1'b0;
			o_charge_q  <= '0;
			o_soc_q     <= '0;
			o_bars_q    <= '0;
		end else if ((state_q == ST_OUT) && can_load) begin
			o_vld_q     <= 1'b1;
			o_mv_q      <= mv_q;
			o_mag_q     <= mag_q;
			o_neg_q     <= neg_q;
			o_tcap_q    <= tcap_q;
			o_started_q <= seeded_q;
			o_charge_q  <= whole_q;
			o_soc_q     <= soc_q;
			o_bars_q    <= bars_d;
		end else if (result.ready) begin
			o_vld_q <= 1'b0;
		end
	end

	assign result.valid             = o_vld_q;
	assign result.bus_millivolts    = o_mv_q;
	assign result.current_magnitude = o_mag_q;
	assign result.current_negative  = o_neg_q;
	assign result.table_capacity    = o_tcap_q;
	assign result.gauge_started     = o_started_q;
	assign result.charge_whole      = o_charge_q;
	assign result.soc_percent       = o_soc_q;
	assign result.led_bars          = o_bars_q;

endmodule

// ===== src/bcfg_ram.sv =====
`timescale 1ns / 1ps

module bcfg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/bcfg_search.sv =====
`timescale 1ns / 1ps

module bcfg_search (
	input  logic                clk,
	input  logic                arst_n,
	input  bcfg_pkg::srch_req_t req,
	output bcfg_pkg::srch_sts_t sts
);

	localparam int AW = bcfg_pkg::TBL_ADDR_W;
	localparam int IW = bcfg_pkg::TBL_IDX_W;
	localparam int CW = bcfg_pkg::CAP_W;

	logic                             fill_q;
	logic [AW-1:0]                    fidx_q;
	logic                             srch_q;
	logic                             cmp_q;
	logic                             done_q;
	logic [IW-1:0]                    idx_q;
	logic [bcfg_pkg::MV_W-1:0]        mv_q;
	logic [CW-1:0]                    best_q;
	logic [CW-1:0]                    cap_q;
	logic [bcfg_pkg::ENTRY_W-1:0]     rdata;
	logic [CW-1:0]                    volt;
	logic [CW-1:0]                    mv_ext;
	logic [CW-1:0]                    delta;
	logic                             last;

	bcfg_ram #(
		.WIDTH(bcfg_pkg::ENTRY_W),
		.DEPTH(bcfg_pkg::TBL_N)
	) u_table (
		.clk   (clk),
		.we    (fill_q),
		.waddr (fidx_q),
		.wdata (bcfg_pkg::VC_TABLE[bcfg_pkg::SLOT_W'(fidx_q)]),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	assign volt   = rdata[bcfg_pkg::ENTRY_W-1:CW];
	assign mv_ext = CW'(mv_q);
	assign delta  = (mv_ext >= volt) ? (mv_ext - volt) : (volt - mv_ext);
	assign last   = (idx_q == IW'(bcfg_pkg::TBL_N));

	// copy the constant table into the memory after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 1'b1;
			fidx_q <= '0;
		end else if (fill_q) begin
			fidx_q <= fidx_q + AW'(1);
			if (fidx_q == AW'(bcfg_pkg::TBL_N - 1)) begin
				fill_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srch_q <= 1'b0;
			cmp_q  <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !srch_q && !fill_q) begin
				srch_q <= 1'b1;
				cmp_q  <= 1'b0;
				idx_q  <= '0;
			end else if (srch_q) begin
				cmp_q <= !last;
				if (last) begin
					srch_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
		end
	end

	// strict compare keeps the first of equal distances
	always_ff @(posedge clk) begin
		if (req.start && !srch_q) begin
			mv_q   <= req.mv;
			best_q <= '1;
		end else if (cmp_q && delta < best_q) begin
			best_q <= delta;
			cap_q  <= rdata[CW-1:0];
		end
	end

	assign sts.idle = !fill_q && !srch_q;
	assign sts.done = done_q;
	assign sts.cap  = cap_q;

endmodule

// ===== src/bcfg_div.sv =====
`timescale 1ns / 1ps

module bcfg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bcfg_pkg::div_req_t req,
	output bcfg_pkg::div_sts_t sts
);

	localparam int NW   = bcfg_pkg::NUM_W;
	localparam int DW   = bcfg_pkg::DEN_W;
	localparam int QW   = bcfg_pkg::QUO_W;
	localparam int DS_W = DW + QW - 1;
	localparam int CNTW = $clog2(QW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   rem_q;
	logic [DS_W-1:0] ds_q;
	logic [QW-1:0]   quo_q;
	logic            ovf_q;
	logic            ge;

	assign ge = (DS_W'(rem_q) >= ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit a cycle, most significant first
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			ds_q  <= {req.den, {(QW-1){1'b0}}};
			quo_q <= '0;
			ovf_q <= ((DS_W + 1)'(req.num) >= {req.den, {QW{1'b0}}});
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - ds_q[NW-1:0];
			end
			quo_q <= {quo_q[QW-2:0], ge};
			ds_q  <= ds_q >> 1;
		end
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign sts.quo  = quo_q;

endmodule

// ===== src/bcfg_checker.sv =====
`timescale 1ns / 1ps

module bcfg_checker (
	input logic            clk,
	input logic            arst_n,
	bcfg_sample_if.sink    sample,
	bcfg_result_if.source  result
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.soc_percent)
			&& $stable(result.charge_whole) && $stable(result.bus_millivolts))
		else $error("stalled result changed");

	// one request in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("request taken while busy");

	// bar count follows SOC
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.soc_percent <= 7'd100
			&& (result.soc_percent > 7'd10 || result.led_bars == 3'd0)
			&& (result.soc_percent <= 7'd80 || result.led_bars == 3'd5))
		else $error("bars disagree with SOC");

	// nothing counted before seeding
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.gauge_started |->
			result.charge_whole == 18'sd0 && result.soc_percent == 7'd0)
		else $error("charge before seeding");

	// seeding is never undone
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(result.gauge_started))
		else $error("gauge started flag dropped");

endmodule

bind battery_coulomb_fuel_gauge bcfg_checker u_bcfg_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.sample (sample),
	.result (result)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int OCV_POINTS  = 51;
	localparam int MAX_LINES   = 40;
	localparam longint CHARGE_TOP = 64'sd2199023255551;
	localparam longint CHARGE_BOT = -64'sd2199023255552;
	localparam longint WHOLE_TOP  = 131071;
	localparam longint WHOLE_BOT  = -131072;

	// open-circuit voltage points; capacity rises 250 per point from 80, last point 12500
	localparam int unsigned OCV_MV [OCV_POINTS] = '{
		10269, 10699, 10883, 10957, 10994, 11028, 11072, 11127, 11188, 11249,
		11307, 11360, 11406, 11448, 11488, 11527, 11567, 11610, 11657, 11707,
		11760, 11816, 11872, 11928, 11983, 12036, 12087, 12136, 12183, 12229,
		12275, 12319, 12363, 12406, 12447, 12486, 12521, 12551, 12575, 12594,
		12606, 12613, 12616, 12617, 12617, 12619, 12623, 12628, 12634, 12637,
		12637
	};

	typedef struct packed {
		logic [bcfg_pkg::MV_W-1:0]  mv;
		logic [bcfg_pkg::MAG_W-1:0] mag;
		logic                       neg;
		logic [bcfg_pkg::CAP_W-1:0] tcap;
		logic                       started;
		logic [bcfg_pkg::CHG_W-1:0] charge;
		logic [bcfg_pkg::SOC_W-1:0] soc;
		logic [bcfg_pkg::BAR_W-1:0] bars;
	} reading_t;

	logic clk;
	logic arst_n;

	bcfg_sample_if sample_ch ();
	bcfg_result_if result_ch ();
	bcfg_cfg_if    cfg_ch ();

	battery_coulomb_fuel_gauge uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// gauge settings and state as the block should hold them
	logic [bcfg_pkg::CAP_W-1:0] cap_setting    = 16'd12500;
	logic [bcfg_pkg::TPH_W-1:0] tph_setting    = 24'd360000;
	logic [bcfg_pkg::THR_W-1:0] thr_setting    = 16'd200;
	logic [bcfg_pkg::SET_W-1:0] settle_setting = 8'd20;
	logic [bcfg_pkg::MV_W-1:0]  mv_now         = '0;
	logic [bcfg_pkg::MAG_W-1:0] mag_now        = '0;
	logic                       neg_now        = 1'b0;
	logic [bcfg_pkg::SET_W-1:0] samples_taken  = '0;
	logic                       charge_seeded  = 1'b0;
	longint                     charge_count   = 0;
	logic [bcfg_pkg::SOC_W-1:0] soc_now        = '0;

	reading_t readings_due [$];
	int       mismatches        = 0;
	int       hold_result_cycles = 0;
	bit       idle_on           = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("battery_coulomb_fuel_gauge: mismatch");
		$finish;
	end

	function automatic int unsigned ocv_capacity(input logic [bcfg_pkg::MV_W-1:0] mv);
		int unsigned best_span;
		int unsigned span;
		int unsigned cap;
		best_span = 32'hFFFF;
		cap = 0;
		// strict compare keeps the first of equally near points
		for (int i = 0; i < OCV_POINTS; i++) begin
			span = (mv >= OCV_MV[i]) ? (mv - OCV_MV[i]) : (OCV_MV[i] - mv);
			if (span < best_span) begin
				best_span = span;
				cap = (i == OCV_POINTS - 1) ? 12500 : 80 + 250 * i;
			end
		end
		return cap;
	endfunction

	function automatic longint clamp_charge(input longint x);
		if (x > CHARGE_TOP)
			return CHARGE_TOP;
		if (x < CHARGE_BOT)
			return CHARGE_BOT;
		return x;
	endfunction

	function automatic reading_t gauge_step(input bcfg_pkg::kind_t k, input logic [15:0] bus,
			input logic [15:0] sh);
		reading_t r;
		longint   tph_eff;
		longint   cap_eff;
		longint   step_mag;
		longint   quotient;
		longint   whole;
		tph_eff = (tph_setting == 0) ? 1 : tph_setting;
		cap_eff = (cap_setting == 0) ? 1 : cap_setting;
		if (k == bcfg_pkg::KIND_SAMPLE) begin
			mv_now  = {bus[15:3], 2'b00};
			neg_now = sh[15];
			mag_now = neg_now ? (~sh + 16'd1) : sh;
			if (samples_taken != 8'hFF)
				samples_taken++;
			if (!charge_seeded && samples_taken > settle_setting && !neg_now) begin
				if (mag_now > thr_setting) begin
					charge_count  = clamp_charge(longint'(ocv_capacity(mv_now)) * tph_eff);
					charge_seeded = 1'b1;
				end else if (mag_now < thr_setting) begin
					charge_count  = clamp_charge(cap_eff * tph_eff);
					charge_seeded = 1'b1;
				end
			end
		end else if (charge_seeded) begin
			step_mag = mag_now;
			charge_count = clamp_charge(neg_now ? charge_count - step_mag
				: charge_count + step_mag);
			if (charge_count <= 0) begin
				soc_now = '0;
			end else begin
				quotient = (charge_count * 100) / (tph_eff * cap_eff);
				soc_now  = (quotient > 100) ? bcfg_pkg::SOC_W'(100)
					: bcfg_pkg::SOC_W'(quotient);
			end
		end
		whole = charge_count / tph_eff;
		if (whole > WHOLE_TOP)
			whole = WHOLE_TOP;
		else if (whole < WHOLE_BOT)
			whole = WHOLE_BOT;
		r.mv      = mv_now;
		r.mag     = mag_now;
		r.neg     = neg_now;
		r.tcap    = bcfg_pkg::CAP_W'(ocv_capacity(mv_now));
		r.started = charge_seeded;
		r.charge  = bcfg_pkg::CHG_W'(whole);
		r.soc     = soc_now;
		if (soc_now <= 10)
			r.bars = 3'd0;
		else if (soc_now <= 20)
			r.bars = 3'd1;
		else if (soc_now <= 40)
			r.bars = 3'd2;
		else if (soc_now <= 60)
			r.bars = 3'd3;
		else if (soc_now <= 80)
			r.bars = 3'd4;
		else
			r.bars = 3'd5;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
		mismatches++;
		if (mismatches <= MAX_LINES)
			$display("%0t ns: %s got %0d, want %0d", $time, what, got_v, want_v);
	endtask

	// result side: random stalls per request, long hold when asked, check every request
	initial begin : result_sink
		int       stall_left;
		reading_t got;
		reading_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.mv      = result_ch.bus_millivolts;
				got.mag     = result_ch.current_magnitude;
				got.neg     = result_ch.current_negative;
				got.tcap    = result_ch.table_capacity;
				got.started = result_ch.gauge_started;
				got.charge  = result_ch.charge_whole;
				got.soc     = result_ch.soc_percent;
				got.bars    = result_ch.led_bars;
				if (readings_due.size() == 0) begin
					report_mismatch("result with nothing due", 0, 0);
				end else begin
					want = readings_due.pop_front();
					if (got.mv !== want.mv)
						report_mismatch("bus_millivolts", got.mv, want.mv);
					if (got.mag !== want.mag)
						report_mismatch("current_magnitude", got.mag, want.mag);
					if (got.neg !== want.neg)
						report_mismatch("current_negative", got.neg, want.neg);
					if (got.tcap !== want.tcap)
						report_mismatch("table_capacity", got.tcap, want.tcap);
					if (got.started !== want.started)
						report_mismatch("gauge_started", got.started, want.started);
					if (got.charge !== want.charge)
						report_mismatch("charge_whole", $signed(got.charge), $signed(want.charge));
					if (got.soc !== want.soc)
						report_mismatch("soc_percent", got.soc, want.soc);
					if (got.bars !== want.bars)
						report_mismatch("led_bars", got.bars, want.bars);
				end
				stall_left = idle_on ? $urandom_range(0, 9) : 0;
			end
			if (hold_result_cycles > 0) begin
				result_ch.ready <= 1'b0;
				hold_result_cycles--;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// valid is left high after acceptance so back-to-back requests never drop it
	task automatic send_item(input bcfg_pkg::kind_t k, input logic [15:0] bus,
			input logic [15:0] sh);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid     <= 1'b1;
		sample_ch.kind      <= k;
		sample_ch.bus_raw   <= bus;
		sample_ch.shunt_raw <= sh;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		readings_due.push_back(gauge_step(k, bus, sh));
	endtask

	task automatic send_random_item(input bcfg_pkg::kind_t k, input int neg_pct,
			input int mag_max);
		logic [15:0] bus;
		logic [15:0] sh;
		int          m;
		// half the voltages land inside the table span
		bus = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(20500, 25300));
		m = $urandom_range(0, mag_max);
		if ($urandom_range(1, 100) <= neg_pct)
			sh = (m == 0) ? 16'h8000 : 16'(-m);
		else
			sh = 16'(m);
		send_item(k, bus, sh);
	endtask

	task automatic wait_drain();
		sample_ch.valid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_settings(input logic [bcfg_pkg::CAP_W-1:0] capv,
			input logic [bcfg_pkg::TPH_W-1:0] tphv, input logic [bcfg_pkg::THR_W-1:0] thrv,
			input logic [bcfg_pkg::SET_W-1:0] setv);
		bcfg_pkg::cfg_idx_t              regs [4];
		logic [bcfg_pkg::CFG_DATA_W-1:0] vals [4];
		regs[0] = bcfg_pkg::CFG_CAPACITY;
		regs[1] = bcfg_pkg::CFG_TPH;
		regs[2] = bcfg_pkg::CFG_THRESHOLD;
		regs[3] = bcfg_pkg::CFG_SETTLE;
		vals[0] = capv;
		vals[1] = tphv;
		vals[2] = thrv;
		vals[3] = setv;
		wait_drain();
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[i];
			cfg_ch.data  <= vals[i];
			@(posedge clk);
			while (!cfg_ch.ready) @(posedge clk);
			case (regs[i])
				bcfg_pkg::CFG_CAPACITY:  cap_setting    = vals[i][bcfg_pkg::CAP_W-1:0];
				bcfg_pkg::CFG_TPH:       tph_setting    = vals[i][bcfg_pkg::TPH_W-1:0];
				bcfg_pkg::CFG_THRESHOLD: thr_setting    = vals[i][bcfg_pkg::THR_W-1:0];
				bcfg_pkg::CFG_SETTLE:    settle_setting = vals[i][bcfg_pkg::SET_W-1:0];
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// reset settings, fewer samples than the settle count: nothing may seed
	task automatic test_power_on_directed();
		send_item(bcfg_pkg::KIND_TICK, 16'h0000, 16'h0100);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'h0000, 16'h0000);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'hFFFF, 16'h7FFF);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'h0007, 16'h8000);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd20968, 16'hFFFF);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd25272, 16'h0001);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd25280, 16'd200);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd25232, 16'd201);
		send_item(bcfg_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'h8000, 16'h0080);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'h5555, 16'hAAAA);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'hAAAA, 16'h5555);
		send_item(bcfg_pkg::KIND_TICK, 16'h0000, 16'h0000);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd24000, 16'd50);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'd21000, 16'd5000);
		send_item(bcfg_pkg::KIND_TICK, 16'h0000, 16'h0000);
	endtask

	// settle count at its top: the saturated sample counter never exceeds it
	task automatic test_settle_limit();
		write_settings(16'd12500, 24'd360000, 16'd200, 8'hFF);
		for (int i = 0; i < 300; i++)
			send_random_item((i % 10 == 9) ? bcfg_pkg::KIND_TICK : bcfg_pkg::KIND_SAMPLE,
				20, 32767);
	endtask

	task automatic test_charge_seeding();
		logic [bcfg_pkg::THR_W-1:0] thr;
		logic [bcfg_pkg::MAG_W-1:0] mag;
		logic                       above;
		case ($urandom_range(0, 2))
			0:       thr = 16'd0;
			1:       thr = 16'h8000;
			default: thr = 16'($urandom_range(1, 32766));
		endcase
		// small capacity and tick rate keep the charge within reach of the bounds later
		write_settings(16'($urandom_range(0, 2000)), 24'($urandom_range(0, 64)), thr,
			8'($urandom_range(0, 254)));
		idle_on = 1'b1;
		send_item(bcfg_pkg::KIND_TICK, 16'h0000, 16'h0000);
		if (thr <= 16'h7FFF)
			send_item(bcfg_pkg::KIND_SAMPLE, 16'($urandom_range(20500, 25300)), thr);
		send_item(bcfg_pkg::KIND_SAMPLE, 16'($urandom_range(20500, 25300)), 16'hFF00);
		if (thr == 16'd0)
			above = 1'b1;
		else if (thr == 16'h8000)
			above = 1'b0;
		else
			above = $urandom_range(0, 1);
		mag = above ? 16'($urandom_range(thr + 1, 32767)) : 16'($urandom_range(0, thr - 1));
		send_item(bcfg_pkg::KIND_SAMPLE, 16'($urandom_range(20500, 25300)), mag);
		repeat (3) send_random_item(bcfg_pkg::KIND_TICK, 0, 32767);
	endtask

	// hold the result side so the block fills and stalls its input
	task automatic test_result_backpressure();
		idle_on = 1'b1;
		hold_result_cycles = 1500;
		repeat (12)
			send_random_item($urandom_range(0, 1) ? bcfg_pkg::KIND_TICK
				: bcfg_pkg::KIND_SAMPLE, 50, 32767);
	endtask

	task automatic test_drain_pause();
		repeat (15)
			send_random_item($urandom_range(0, 1) ? bcfg_pkg::KIND_TICK
				: bcfg_pkg::KIND_SAMPLE, 50, 4095);
		wait_drain();
		repeat (15)
			send_random_item($urandom_range(0, 1) ? bcfg_pkg::KIND_TICK
				: bcfg_pkg::KIND_SAMPLE, 50, 4095);
	endtask

	task automatic test_random_phases();
		logic [bcfg_pkg::CAP_W-1:0] capv;
		logic [bcfg_pkg::TPH_W-1:0] tphv;
		int                         neg_pct;
		int                         mag_max;
		bcfg_pkg::kind_t            k;
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 4))
				0:       capv = 16'd0;
				1:       capv = 16'd1;
				2:       capv = 16'hFFFF;
				3:       capv = 16'($urandom_range(1, 2000));
				default: capv = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 4))
				0:       tphv = 24'd0;
				1:       tphv = 24'd1;
				2:       tphv = 24'hFFFFFF;
				3:       tphv = 24'($urandom_range(1, 64));
				default: tphv = 24'd360000;
			endcase
			if (p == 0)
				write_settings(16'd1, 24'd1, 16'd0, 8'd0);
			else if (p == 1)
				write_settings(16'hFFFF, 24'hFFFFFF, 16'h8000, 8'hFF);
			else
				write_settings(capv, tphv, 16'($urandom_range(0, 32768)), 8'($urandom));
			idle_on = (p % 3) != 2;
			case ($urandom_range(0, 2))
				0:       neg_pct = 10;
				1:       neg_pct = 50;
				default: neg_pct = 90;
			endcase
			case ($urandom_range(0, 3))
				0:       mag_max = 15;
				1:       mag_max = 255;
				2:       mag_max = 4095;
				default: mag_max = 32767;
			endcase
			repeat (115) begin
				k = ($urandom_range(1, 100) <= 60) ? bcfg_pkg::KIND_TICK
					: bcfg_pkg::KIND_SAMPLE;
				send_random_item(k, neg_pct, mag_max);
			end
		end
	endtask

	initial begin
		arst_n              <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.kind      <= bcfg_pkg::KIND_SAMPLE;
		sample_ch.bus_raw   <= '0;
		sample_ch.shunt_raw <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= bcfg_pkg::CFG_CAPACITY;
		cfg_ch.data         <= '0;
		result_ch.ready     <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_power_on_directed();
		test_settle_limit();
		test_charge_seeding();
		test_result_backpressure();
		test_drain_pause();
		test_random_phases();

		wait_drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && readings_due.size() == 0)
			$display("battery_coulomb_fuel_gauge: match");
		else
			$display("battery_coulomb_fuel_gauge: mismatch");
		$finish;
	end

endmodule
